/* hdl/tlprs_pkg.sv */
package tlprs_pkg;

    // Number of task slots; task ids are 4 bits wide
    localparam int NUM_TASKS = 16;

    // Slot placement codes
    typedef enum logic [1:0] {
        PLACE_ABSENT = 2'd0,
        PLACE_L1     = 2'd1,
        PLACE_L2     = 2'd2
    } place_t;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [7:0] QUANTUM_RESET = 8'd2;

    // Result of one level-one scan
    typedef struct packed {
        logic       found;
        logic [5:0] slot;
    } pick_t;

endpackage

/* hdl/tlprs_scan.sv */
// Sequential minimum search over level-one slots, one slot per cycle.
module tlprs_scan
    import tlprs_pkg::*;
#(
    parameter int NUM_TASKS = 16,
    parameter int IDX_W     = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 slot_is_l1,
    input  logic [3:0]           slot_prio,
    input  logic [7:0]           slot_age,
    output logic [IDX_W-1:0]     slot_idx,
    output logic                 done,
    output pick_t                pick
);

    logic              busy_reg;
    logic [IDX_W:0]    cnt_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  best_reg;
    logic [3:0]        bp_reg;
    logic [7:0]        ba_reg;
    logic              better;

    assign slot_idx = cnt_reg[IDX_W-1:0];
    assign done     = busy_reg && (cnt_reg == (IDX_W+1)'(NUM_TASKS - 1));

    // Compare the current slot with the best so far
    assign better = slot_is_l1 && (!found_reg || slot_prio < bp_reg ||
                    (slot_prio == bp_reg && slot_age > ba_reg));

    always_comb
    begin
        pick.found = found_reg || better;
        pick.slot  = better ? 6'(cnt_reg[IDX_W-1:0]) : 6'(best_reg);
    end

    // Advance the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            best_reg  <= '0;
            bp_reg    <= '0;
            ba_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (better)
            begin
                found_reg <= 1'b1;
                best_reg  <= cnt_reg[IDX_W-1:0];
                bp_reg    <= slot_prio;
                ba_reg    <= slot_age;
            end
            if (done)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

endmodule

/* hdl/two_level_priority_rr_scheduler_unit.sv */
// Two-level task scheduler over NUM_TASKS slots (16). Arrival requests (op 0)
// are accepted and then load a task slot into level one in ST_ARRIVE. Tick
// requests (op 1) are accepted, then a shared comparator walks the slot tables
// one slot per cycle to find the best level-one task (lowest priority number,
// then oldest arrival), then ST_APPLY updates the tables and the round-robin
// FIFO and posts the result, and the output register hands it over. The input
// is not ready while a request is being worked on or while a result waits in
// the output register, so an output stall delays the next request. The
// quantum register may be written only while idle.
module two_level_priority_rr_scheduler_unit
    import tlprs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: op[0], task_id[4:1], burst[12:5], priority_req[16:13], pad to 24
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // m_tdata: run_valid[0], run_task[4:1], from_level_two[5], finished[6],
    //          now_time[22:7], pad to 24
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [1:0] {ST_IDLE, ST_ARRIVE, ST_SCAN, ST_APPLY} state_t;

    state_t state_reg;
    logic [23:0] req_reg;

    logic [7:0]       work_reg  [NUM_TASKS];
    logic [3:0]       prio_reg  [NUM_TASKS];
    logic [7:0]       stamp_reg [NUM_TASKS];
    logic [IDX_W-1:0] fifo_reg  [NUM_TASKS];
    place_t           place_reg [NUM_TASKS];

    logic [7:0]       stamp_cnt_reg;
    logic [IDX_W-1:0] rr_head_reg;
    logic [CNT_W-1:0] rr_count_reg;
    logic [IDX_W-1:0] cur_task_reg;
    logic             cur_valid_reg;
    logic [7:0]       slice_reg;
    logic [15:0]      time_reg;
    logic [7:0]       quantum_reg;

    logic             out_valid_reg;
    logic [22:0]      out_data_reg;

    logic             req_op;
    logic [3:0]       req_id;
    logic [7:0]       req_burst;
    logic [3:0]       req_prio;

    logic             scan_start;
    logic [IDX_W-1:0] scan_idx;
    logic             scan_done;
    pick_t            scan_pick;
    pick_t            pick_reg;

    assign req_op    = req_reg[0];
    assign req_id    = req_reg[4:1];
    assign req_burst = req_reg[12:5];
    assign req_prio  = req_reg[16:13];

    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_data_reg};
    assign scan_start = (state_reg == ST_IDLE) && s_tvalid && s_tready &&
                        (s_tdata[0] == OP_TICK);

    tlprs_scan #(.NUM_TASKS(NUM_TASKS), .IDX_W(IDX_W)) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .slot_is_l1 (place_reg[scan_idx] == PLACE_L1),
        .slot_prio  (prio_reg[scan_idx]),
        .slot_age   (stamp_cnt_reg - stamp_reg[scan_idx]),
        .slot_idx   (scan_idx),
        .done       (scan_done),
        .pick       (scan_pick)
    );

    // Decision for the tick, evaluated in ST_APPLY
    logic             in_slice;
    logic             use_l1;
    logic [IDX_W-1:0] best;
    logic [IDX_W-1:0] head_task;
    logic [7:0]       qnt;
    logic [7:0]       head_work_dec;
    logic [7:0]       slice_inc;
    logic             id_ok;

    assign in_slice  = cur_valid_reg && (place_reg[cur_task_reg] == PLACE_L2);
    assign use_l1    = !in_slice && pick_reg.found;
    assign best      = pick_reg.slot[IDX_W-1:0];
    assign head_task = fifo_reg[rr_head_reg];
    assign qnt       = (quantum_reg == 8'd0) ? 8'd1 : quantum_reg;
    assign head_work_dec = (work_reg[head_task] != 8'd0) ?
                           work_reg[head_task] - 8'd1 : 8'd0;
    assign slice_inc = ((cur_valid_reg && cur_task_reg == head_task) ?
                        slice_reg : 8'd0) + 8'd1;
    assign id_ok     = (5'(req_id) < 5'(NUM_TASKS));

    // Sequencer, tables and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < NUM_TASKS; i++)
                place_reg[i] <= PLACE_ABSENT;
            stamp_cnt_reg <= '0;
            rr_head_reg   <= '0;
            rr_count_reg  <= '0;
            cur_task_reg  <= '0;
            cur_valid_reg <= 1'b0;
            slice_reg     <= '0;
            time_reg      <= '0;
            quantum_reg   <= QUANTUM_RESET;
            out_valid_reg <= 1'b0;
            pick_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                quantum_reg <= cfg_data;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        req_reg   <= s_tdata;
                        state_reg <= (s_tdata[0] == OP_TICK) ? ST_SCAN : ST_ARRIVE;
                    end
                end
                ST_ARRIVE:
                begin
                    // Load a new slot unless ignored
                    if (req_burst != 8'd0 && id_ok &&
                        place_reg[req_id[IDX_W-1:0]] == PLACE_ABSENT)
                    begin
                        work_reg[req_id[IDX_W-1:0]]  <= req_burst;
                        prio_reg[req_id[IDX_W-1:0]]  <= req_prio;
                        stamp_reg[req_id[IDX_W-1:0]] <= stamp_cnt_reg;
                        place_reg[req_id[IDX_W-1:0]] <= PLACE_L1;
                        stamp_cnt_reg <= stamp_cnt_reg + 8'd1;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    if (scan_done)
                    begin
                        pick_reg  <= scan_pick;
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY:
                begin
                    out_valid_reg       <= 1'b1;
                    out_data_reg[22:7]  <= time_reg + 16'd1;
                    time_reg            <= time_reg + 16'd1;
                    if (use_l1)
                    begin
                        // Demote a displaced level-one task
                        if (cur_valid_reg && cur_task_reg != best &&
                            place_reg[cur_task_reg] == PLACE_L1 &&
                            work_reg[cur_task_reg] != 8'd0 &&
                            rr_count_reg < CNT_W'(NUM_TASKS))
                        begin
                            fifo_reg[IDX_W'(rr_head_reg + rr_count_reg[IDX_W-1:0])]
                                <= cur_task_reg;
                            rr_count_reg <= rr_count_reg + 1'b1;
                            place_reg[cur_task_reg] <= PLACE_L2;
                        end
                        work_reg[best] <= work_reg[best] - 8'd1;
                        slice_reg      <= '0;
                        out_data_reg[6:0] <= {work_reg[best] == 8'd1, 1'b0,
                                              4'(best), 1'b1};
                        if (work_reg[best] == 8'd1)
                        begin
                            place_reg[best] <= PLACE_ABSENT;
                            cur_valid_reg   <= 1'b0;
                        end
                        else
                        begin
                            cur_task_reg  <= best;
                            cur_valid_reg <= 1'b1;
                        end
                    end
                    else if (rr_count_reg != '0)
                    begin
                        work_reg[head_task] <= head_work_dec;
                        out_data_reg[6:0] <= {head_work_dec == 8'd0, 1'b1,
                                              4'(head_task), 1'b1};
                        if (head_work_dec == 8'd0)
                        begin
                            rr_head_reg  <= rr_head_reg + 1'b1;
                            rr_count_reg <= rr_count_reg - 1'b1;
                            place_reg[head_task] <= PLACE_ABSENT;
                            cur_valid_reg <= 1'b0;
                            slice_reg     <= '0;
                        end
                        else if (slice_inc >= qnt)
                        begin
                            // Rotate head to tail
                            fifo_reg[IDX_W'(rr_head_reg + rr_count_reg[IDX_W-1:0])]
                                <= head_task;
                            rr_head_reg   <= rr_head_reg + 1'b1;
                            cur_valid_reg <= 1'b0;
                            slice_reg     <= '0;
                        end
                        else
                        begin
                            cur_task_reg  <= head_task;
                            cur_valid_reg <= 1'b1;
                            slice_reg     <= slice_inc;
                        end
                    end
                    else
                    begin
                        out_data_reg[6:0] <= '0;
                        cur_valid_reg     <= 1'b0;
                        slice_reg         <= '0;
                    end
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* hdl/tlprs_checker.sv */
module tlprs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An accepted request makes the input busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a request");

    // Idle result carries no task
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == 6'd0)
        else $error("idle result carries a task");

    // An arrival never raises a result
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tdata[0] && !m_tvalid |=> ##1 !m_tvalid)
        else $error("result after an arrival");

endmodule

bind two_level_priority_rr_scheduler_unit tlprs_checker u_tlprs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
